### rtl/cau_pkg.sv
`default_nettype none
package cau_pkg;

	// Operation codes carried in the mode field
	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	// Quotient bits produced by the back end, one per stage
	localparam int unsigned DIV_STEPS = 32;

	localparam logic signed [31:0] RES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

	// Input transaction
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] a_re;
		logic signed [15:0] a_im;
		logic signed [15:0] b_re;
		logic signed [15:0] b_im;
	} req_t;

	// Result transaction
	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic               divide_by_zero;
		logic               saturated;
	} rsp_t;

	// Classified job handed from front end to back end
	typedef struct packed {
		logic               is_div;
		logic               dz;
		logic               neg_re;
		logic               neg_im;
		logic [31:0]        mag_re;
		logic [31:0]        mag_im;
		logic [31:0]        den;
		logic signed [31:0] dir_re;
		logic signed [31:0] dir_im;
		logic               dir_sat;
	} job_t;

	// One stage of the divider pipeline
	typedef struct packed {
		logic               is_div;
		logic               dz;
		logic               neg_re;
		logic               neg_im;
		logic               ovf_re;
		logic               ovf_im;
		logic [31:0]        den;
		logic [31:0]        rem_re;
		logic [31:0]        rem_im;
		logic [31:0]        low_re;
		logic [31:0]        low_im;
		logic [31:0]        q_re;
		logic [31:0]        q_im;
		logic signed [31:0] dir_re;
		logic signed [31:0] dir_im;
		logic               dir_sat;
	} stage_t;

	// True when a 33-bit signed value does not fit in 32 bits
	function automatic logic out_of_range(input logic signed [32:0] x);
		return x[32] != x[31];
	endfunction

	// Clamp a 33-bit signed value to 32 bits
	function automatic logic signed [31:0] clamp33(input logic signed [32:0] x);
		logic signed [31:0] r;
		r = x[31:0];
		if (x[32] != x[31]) begin
			r = x[32] ? RES_MIN : RES_MAX;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/cau_stream_if.sv
`default_nettype none
interface cau_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/complex_arithmetic_unit.sv
// Complex ALU for Q7.8 operands giving Q15.16 results: add, subtract, multiply and
// divide (A/B as A*conj(B)/|B|^2, truncated toward zero), with saturation and a
// divide-by-zero flag. It accepts one transaction per clock and returns one result
// per clock in order while the result sink is ready. A transaction passes through
// the front end, the queue, 33 divider stages and the output register. Every mode
// runs through the 32-step restoring divider pipeline so results stay ordered.
// The front end and back end stall independently through a QUEUE_DEPTH-entry queue.
`default_nettype none
module complex_arithmetic_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cau_stream_if.sink   req,
	cau_stream_if.source rsp
);
	import cau_pkg::*;

	logic f_valid, f_ready, b_valid, b_ready;
	job_t f_data, b_data;

	cau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (f_valid),
		.push_data  (f_data),
		.push_ready (f_ready)
	);

	cau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_data  (f_data),
		.push_ready (f_ready),
		.pop_valid  (b_valid),
		.pop_data   (b_data),
		.pop_ready  (b_ready)
	);

	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_data  (b_data),
		.pop_ready (b_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

### rtl/cau_front.sv
`default_nettype none
module cau_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	cau_stream_if.sink       req,
	output logic             push_valid,
	output cau_pkg::job_t    push_data,
	input  wire logic        push_ready
);
	import cau_pkg::*;

	logic               v_s1, v_s2;
	logic               en_s1, en_s2;
	req_t               r_s1;
	logic [1:0]         mode_s2;
	logic signed [31:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2, p_bb_s2, p_cc_s2;
	logic signed [16:0] as_re_s2, as_im_s2;

	logic signed [32:0] m_re, m_im, n_re, n_im, d_sum;

	// Advance each stage when the next one has room
	assign en_s2     = !v_s2 || push_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// Capture the operands
	always_ff @(posedge clk) begin
		if (en_s1) r_s1 <= req.data;
	end

	// Form all partial products and the add/subtract sums
	always_ff @(posedge clk) begin
		if (en_s2) begin
			mode_s2  <= r_s1.mode;
			p_rr_s2  <= $signed(r_s1.a_re) * $signed(r_s1.b_re);
			p_ii_s2  <= $signed(r_s1.a_im) * $signed(r_s1.b_im);
			p_ir_s2  <= $signed(r_s1.a_im) * $signed(r_s1.b_re);
			p_ri_s2  <= $signed(r_s1.a_re) * $signed(r_s1.b_im);
			p_bb_s2  <= $signed(r_s1.b_re) * $signed(r_s1.b_re);
			p_cc_s2  <= $signed(r_s1.b_im) * $signed(r_s1.b_im);
			if (mode_t'(r_s1.mode) == MODE_SUB) begin
				as_re_s2 <= 17'($signed(r_s1.a_re)) - 17'($signed(r_s1.b_re));
				as_im_s2 <= 17'($signed(r_s1.a_im)) - 17'($signed(r_s1.b_im));
			end else begin
				as_re_s2 <= 17'($signed(r_s1.a_re)) + 17'($signed(r_s1.b_re));
				as_im_s2 <= 17'($signed(r_s1.a_im)) + 17'($signed(r_s1.b_im));
			end
		end
	end

	// Classify and build the job for the back end
	assign m_re  = 33'(p_rr_s2) - 33'(p_ii_s2);
	assign m_im  = 33'(p_ir_s2) + 33'(p_ri_s2);
	assign n_re  = 33'(p_rr_s2) + 33'(p_ii_s2);
	assign n_im  = 33'(p_ir_s2) - 33'(p_ri_s2);
	assign d_sum = 33'(p_bb_s2) + 33'(p_cc_s2);

	always_comb begin
		push_data = '0;
		unique case (mode_t'(mode_s2))
			MODE_ADD, MODE_SUB: begin
				push_data.dir_re = {{7{as_re_s2[16]}}, as_re_s2, 8'd0};
				push_data.dir_im = {{7{as_im_s2[16]}}, as_im_s2, 8'd0};
			end
			MODE_MUL: begin
				push_data.dir_re  = clamp33(m_re);
				push_data.dir_im  = clamp33(m_im);
				push_data.dir_sat = out_of_range(m_re) || out_of_range(m_im);
			end
			MODE_DIV: begin
				if (d_sum == '0) begin
					push_data.dz = 1'b1;
				end else begin
					push_data.is_div = 1'b1;
					push_data.den    = d_sum[31:0];
					push_data.neg_re = n_re[32];
					push_data.neg_im = n_im[32];
					push_data.mag_re = n_re[32] ? 32'(-n_re) : n_re[31:0];
					push_data.mag_im = n_im[32] ? 32'(-n_im) : n_im[31:0];
				end
			end
			default: ;
		endcase
	end

	assign push_valid = v_s2;

endmodule
`default_nettype wire

### rtl/cau_queue.sv
`default_nettype none
module cau_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	input  cau_pkg::job_t    push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output cau_pkg::job_t    pop_data,
	input  wire logic        pop_ready
);
	import cau_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem[rd_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

### rtl/cau_back.sv
`default_nettype none
module cau_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pop_valid,
	input  cau_pkg::job_t    pop_data,
	output logic             pop_ready,
	cau_stream_if.source     rsp
);
	import cau_pkg::*;

	stage_t st  [DIV_STEPS+1];
	logic   v   [DIV_STEPS+1];
	logic   en  [DIV_STEPS+1];
	logic   en_out;
	logic   out_v_q;
	rsp_t   out_q;

	// Stall chain from the output register back to the queue
	assign en_out = !out_v_q || rsp.ready;
	assign en[DIV_STEPS] = !v[DIV_STEPS] || en_out;
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_en
		assign en[k] = !v[k] || en[k+1];
	end
	assign pop_ready = en[0];

	// Load the first stage: overflow check and initial remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v[0] <= 1'b0;
		else if (en[0]) v[0] <= pop_valid;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			st[0].is_div  <= pop_data.is_div;
			st[0].dz      <= pop_data.dz;
			st[0].neg_re  <= pop_data.neg_re;
			st[0].neg_im  <= pop_data.neg_im;
			st[0].ovf_re  <= {16'd0, pop_data.mag_re[31:16]} >= pop_data.den;
			st[0].ovf_im  <= {16'd0, pop_data.mag_im[31:16]} >= pop_data.den;
			st[0].den     <= pop_data.den;
			st[0].rem_re  <= {16'd0, pop_data.mag_re[31:16]};
			st[0].rem_im  <= {16'd0, pop_data.mag_im[31:16]};
			st[0].low_re  <= {pop_data.mag_re[15:0], 16'd0};
			st[0].low_im  <= {pop_data.mag_im[15:0], 16'd0};
			st[0].q_re    <= '0;
			st[0].q_im    <= '0;
			st[0].dir_re  <= pop_data.dir_re;
			st[0].dir_im  <= pop_data.dir_im;
			st[0].dir_sat <= pop_data.dir_sat;
		end
	end

	// One restoring-division step per stage for both parts
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [32:0] t_re, t_im;
		logic        ge_re, ge_im;
		stage_t      nxt;

		assign t_re  = {st[k-1].rem_re, st[k-1].low_re[31]};
		assign t_im  = {st[k-1].rem_im, st[k-1].low_im[31]};
		assign ge_re = t_re >= {1'b0, st[k-1].den};
		assign ge_im = t_im >= {1'b0, st[k-1].den};

		// Shift in one numerator bit, subtract where it fits
		always_comb begin
			nxt        = st[k-1];
			nxt.rem_re = ge_re ? 32'(t_re - {1'b0, st[k-1].den}) : t_re[31:0];
			nxt.rem_im = ge_im ? 32'(t_im - {1'b0, st[k-1].den}) : t_im[31:0];
			nxt.low_re = {st[k-1].low_re[30:0], 1'b0};
			nxt.low_im = {st[k-1].low_im[30:0], 1'b0};
			nxt.q_re   = {st[k-1].q_re[30:0], ge_re};
			nxt.q_im   = {st[k-1].q_im[30:0], ge_im};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v[k] <= 1'b0;
			else if (en[k]) v[k] <= v[k-1];
		end

		always_ff @(posedge clk) begin
			if (en[k]) st[k] <= nxt;
		end
	end

	// Apply sign and clamp, then hold the result for the sink
	logic [31:0]        lim_re, lim_im;
	logic               sat_re, sat_im;
	logic signed [31:0] fin_re, fin_im;

	always_comb begin
		lim_re = st[DIV_STEPS].neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
		lim_im = st[DIV_STEPS].neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
		sat_re = st[DIV_STEPS].ovf_re || (st[DIV_STEPS].q_re > lim_re);
		sat_im = st[DIV_STEPS].ovf_im || (st[DIV_STEPS].q_im > lim_im);
		if (sat_re) fin_re = st[DIV_STEPS].neg_re ? RES_MIN : RES_MAX;
		else        fin_re = st[DIV_STEPS].neg_re ? -$signed(st[DIV_STEPS].q_re)
		                                          : $signed(st[DIV_STEPS].q_re);
		if (sat_im) fin_im = st[DIV_STEPS].neg_im ? RES_MIN : RES_MAX;
		else        fin_im = st[DIV_STEPS].neg_im ? -$signed(st[DIV_STEPS].q_im)
		                                          : $signed(st[DIV_STEPS].q_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en_out) out_v_q <= v[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_q.divide_by_zero <= st[DIV_STEPS].dz;
			if (st[DIV_STEPS].is_div) begin
				out_q.res_re    <= fin_re;
				out_q.res_im    <= fin_im;
				out_q.saturated <= sat_re || sat_im;
			end else begin
				out_q.res_re    <= st[DIV_STEPS].dir_re;
				out_q.res_im    <= st[DIV_STEPS].dir_im;
				out_q.saturated <= st[DIV_STEPS].dir_sat;
			end
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

endmodule
`default_nettype wire

### dv/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit;
	import cau_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cau_stream_if #(.T(req_t)) req ();
	cau_stream_if #(.T(rsp_t)) rsp ();

	complex_arithmetic_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Directed stimulus; want_fixed marks rows whose result is typed in
	typedef struct {
		mode_t       mode;
		logic [15:0] ar, ai, br, bi;
		logic        want_fixed;
		rsp_t        want;
	} vec_t;

	localparam int NUM_VEC = 18;
	localparam int NUM_RAND = 1450;

	vec_t vecs [NUM_VEC];
	rsp_t result_q[$];
	int mismatches = 0;
	bit stim_done = 1'b0;
	bit hold_rsp = 1'b0;

	always #2 clk = ~clk;

	// Predict one result from one operation
	function automatic rsp_t predict_complex(req_t r);
		rsp_t o;
		longint ar, ai, br, bi, re, im, den;
		ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
		re = 0; im = 0;
		o.divide_by_zero = 1'b0;
		o.saturated = 1'b0;
		case (mode_t'(r.mode))
			MODE_ADD: begin
				re = (ar + br) * 256; im = (ai + bi) * 256;
			end
			MODE_SUB: begin
				re = (ar - br) * 256; im = (ai - bi) * 256;
			end
			MODE_MUL: begin
				re = ar * br - ai * bi; im = ai * br + ar * bi;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					o.divide_by_zero = 1'b1;
				end else begin
					re = ((ar * br + ai * bi) * 65536) / den;
					im = ((ai * br - ar * bi) * 65536) / den;
				end
			end
		endcase
		if (re > 64'sd2147483647) begin re = 64'sd2147483647; o.saturated = 1'b1; end
		if (re < -64'sd2147483648) begin re = -64'sd2147483648; o.saturated = 1'b1; end
		if (im > 64'sd2147483647) begin im = 64'sd2147483647; o.saturated = 1'b1; end
		if (im < -64'sd2147483648) begin im = -64'sd2147483648; o.saturated = 1'b1; end
		o.res_re = re[31:0];
		o.res_im = im[31:0];
		return o;
	endfunction

	function automatic vec_t mk(mode_t m, logic [15:0] ar, logic [15:0] ai,
			logic [15:0] br, logic [15:0] bi, logic fx, logic [31:0] wr,
			logic [31:0] wi, logic dz, logic st);
		vec_t v;
		v.mode = m; v.ar = ar; v.ai = ai; v.br = br; v.bi = bi;
		v.want_fixed = fx;
		v.want = '{res_re: wr, res_im: wi, divide_by_zero: dz, saturated: st};
		return v;
	endfunction

	initial begin
		vecs[0]  = mk(MODE_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			32'd0, 32'd0, 1'b0, 1'b0);
		vecs[1]  = mk(MODE_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
			32'h00FF_FE00, 32'h00FF_FE00, 1'b0, 1'b0);
		vecs[2]  = mk(MODE_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1,
			32'hFF00_0000, 32'hFF00_0000, 1'b0, 1'b0);
		vecs[3]  = mk(MODE_SUB, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b1,
			32'h00FF_FF00, 32'hFF00_0100, 1'b0, 1'b0);
		vecs[4]  = mk(MODE_SUB, 16'h0100, 16'h0200, 16'h0300, 16'hFF00, 1'b0,
			32'd0, 32'd0, 1'b0, 1'b0);
		// both operands -128-128i: imaginary part clamps high
		vecs[5]  = mk(MODE_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1,
			32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
		vecs[6]  = mk(MODE_MUL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0,
			32'd0, 32'd0, 1'b0, 1'b0);
		vecs[7]  = mk(MODE_MUL, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0,
			32'd0, 32'd0, 1'b0, 1'b0);
		vecs[8]  = mk(MODE_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1,
			32'h0001_0000, 32'd0, 1'b0, 1'b0);
		// divide by zero
		vecs[9]  = mk(MODE_DIV, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b1,
			32'd0, 32'd0, 1'b1, 1'b0);
		vecs[10] = mk(MODE_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			32'd0, 32'd0, 1'b1, 1'b0);
		vecs[11] = mk(MODE_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1,
			32'h0001_0000, 32'd0, 1'b0, 1'b0);
		// tiny divisor: large quotients that still fit without clamping
		vecs[12] = mk(MODE_DIV, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 1'b0,
			32'd0, 32'd0, 1'b0, 1'b0);
		vecs[13] = mk(MODE_DIV, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0,
			32'd0, 32'd0, 1'b0, 1'b0);
		vecs[14] = mk(MODE_DIV, 16'h0001, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b0,
			32'd0, 32'd0, 1'b0, 1'b0);
		// truncation toward zero on negative quotient
		vecs[15] = mk(MODE_DIV, 16'hFFFF, 16'h0001, 16'h0300, 16'h0000, 1'b0,
			32'd0, 32'd0, 1'b0, 1'b0);
		vecs[16] = mk(MODE_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0,
			32'd0, 32'd0, 1'b0, 1'b0);
		vecs[17] = mk(MODE_SUB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0,
			32'd0, 32'd0, 1'b0, 1'b0);
	end

	function automatic logic [15:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 3)) - 16'd1;
			3: return 16'($urandom_range(0, 511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one transaction; drop valid only across an idle gap
	task automatic send_item(req_t r, logic fx, rsp_t w);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		result_q.push_back(fx ? w : predict_complex(r));
	endtask

	// Drive stimulus
	initial begin
		req_t r;
		rsp_t none;
		req.valid = 1'b0;
		req.data = '0;
		none = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NUM_VEC; i++) begin
			r = '{mode: vecs[i].mode, a_re: vecs[i].ar, a_im: vecs[i].ai,
				b_re: vecs[i].br, b_im: vecs[i].bi};
			send_item(r, vecs[i].want_fixed, vecs[i].want);
		end
		for (int i = 0; i < NUM_RAND; i++) begin
			r.mode = 2'($urandom);
			r.a_re = rand_part();
			r.a_im = rand_part();
			r.b_re = rand_part();
			r.b_im = rand_part();
			if (r.mode == MODE_DIV && $urandom_range(0, 15) == 0) begin
				r.b_re = '0; r.b_im = '0;
			end
			// back-to-back burst while the receiver is held off
			if (i == 400) hold_rsp = 1'b1;
			if (i >= 400 && i < 460) begin
				req.valid <= 1'b1;
				req.data <= r;
				@(posedge clk);
				while (!req.ready) @(posedge clk);
				result_q.push_back(predict_complex(r));
			end else begin
				send_item(r, 1'b0, none);
			end
		end
		req.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Drive ready: random stalls, plus one long hold-off
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				repeat (120) @(posedge clk);
				hold_rsp = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		rsp_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", rsp.data);
			end else begin
				w = result_q.pop_front();
				if (rsp.data.res_re !== w.res_re || rsp.data.res_im !== w.res_im ||
						rsp.data.divide_by_zero !== w.divide_by_zero ||
						rsp.data.saturated !== w.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected re=%h im=%h dz=%b sat=%b, ",
							"got re=%h im=%h dz=%b sat=%b"},
							w.res_re, w.res_im, w.divide_by_zero, w.saturated,
							rsp.data.res_re, rsp.data.res_im,
							rsp.data.divide_by_zero, rsp.data.saturated);
				end
			end
		end
	end

	// Wait for drain, then report
	initial begin
		wait (stim_done);
		while (result_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
